// File: hw/rtl/assert_macros.svh
// Assertion macros used by the checker file of the RC setpoint block.
// Depends on nothing; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, masked while reset is high.
`define RCATT_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("rcatt assertion failed");

// Clocked assertion that also holds across reset.
`define RCATT_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("rcatt assertion failed");

`endif

// File: hw/rtl/rcatt_pkg.sv
// Types and constants of the RC stick to attitude setpoint block.
// Depends on nothing; used by the lanes, the merge stage and the top level.
package rcatt_pkg;

  localparam int CAL_W = 12;
  typedef logic signed [CAL_W-1:0] cal_t;

  localparam int NUM_CH = 4;
  localparam int CH_ROLL = 0;
  localparam int CH_PITCH = 1;
  localparam int CH_RUD = 2;
  localparam int CH_THR = 3;

  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 16;
  localparam int OFFSET_W = 13;
  localparam int SCALE_W = 16;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_ROLL = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_PITCH = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_RUD = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_THR = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE_ROLL = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE_PITCH = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE_RUD = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE_THR = 3'd7;
  localparam logic [SCALE_W-1:0] SCALE_ONE = 16'd4096;

  localparam int SCALE_SH = 12;
  localparam cal_t CAL_MIN = -12'sd1000;
  localparam cal_t CAL_MAX = 12'sd2000;
  localparam cal_t SNAP_LO = 12'sd485;
  localparam cal_t SNAP_HI = 12'sd515;
  localparam cal_t CAL_CENTER = 12'sd500;
  localparam cal_t CAL_ABSENT = -12'sd100;
  localparam cal_t ARM_THR_LIM = 12'sd20;
  localparam cal_t ARM_RUD_LIM = 12'sd850;
  localparam cal_t DISARM_LIM = 12'sd30;

  localparam int SP_W = 16;
  localparam int YAW_W = 17;
  localparam int IMU_W = 17;
  localparam logic signed [SP_W-1:0] TILT_LIM = 16'sd23040;
  localparam logic signed [17:0] HALF_TURN = 18'sd46080;
  localparam logic signed [18:0] FULL_TURN = 19'sd92160;

  // floor(x / 500) = (x * DIV_RECIP) >> DIV_SH, exact for x below 2^26
  localparam int RECIP_W = 27;
  localparam logic [RECIP_W-1:0] DIV_RECIP = 27'd68719477;
  localparam int DIV_SH = 35;
  localparam int DIV_BIAS = 250;

  typedef struct packed {
    logic load;
    logic cal_en;
    logic mul_en;
    logic abs_en;
    logic div_en;
    logic commit;
  } stage_ctl_t;

  typedef struct packed {
    logic armed;
    logic link;
    logic signed [SP_W-1:0] roll;
    logic signed [SP_W-1:0] pitch;
    logic signed [YAW_W-1:0] yaw;
  } res_t;

endpackage

// File: hw/rtl/rcatt_if.sv
// Handshake interfaces for stick words in and setpoint words out.
// Depends on nothing.
interface rcatt_in_if #(
  parameter int RAW_BITS = 12
);
  logic valid;
  logic ready;
  logic [RAW_BITS-1:0] raw_roll;
  logic [RAW_BITS-1:0] raw_pitch;
  logic [RAW_BITS-1:0] raw_yaw_stick;
  logic [RAW_BITS-1:0] raw_throttle;
  logic [3:0] present_mask;
  logic signed [16:0] imu_yaw;

  modport source (
    output valid, raw_roll, raw_pitch, raw_yaw_stick, raw_throttle, present_mask, imu_yaw,
    input ready
  );
  modport sink (
    input valid, raw_roll, raw_pitch, raw_yaw_stick, raw_throttle, present_mask, imu_yaw,
    output ready
  );
endinterface

interface rcatt_out_if;
  logic valid;
  logic ready;
  logic armed_flag;
  logic link_ok;
  logic signed [15:0] roll_setpoint;
  logic signed [15:0] pitch_setpoint;
  logic signed [16:0] yaw_setpoint;

  modport source (
    output valid, armed_flag, link_ok, roll_setpoint, pitch_setpoint, yaw_setpoint,
    input ready
  );
  modport sink (
    input valid, armed_flag, link_ok, roll_setpoint, pitch_setpoint, yaw_setpoint,
    output ready
  );
endinterface

// File: hw/rtl/rcatt_lane.sv
// Calibration lane: (raw + offset) * scale, floor by 4096, saturate, snap, absent.
// Depends on rcatt_pkg.
module rcatt_lane import rcatt_pkg::*; #(
  parameter int RAW_BITS = 12,
  parameter bit SNAP = 1'b1
) (
  input  logic                       clk,
  input  stage_ctl_t                 ctl,
  input  logic [RAW_BITS-1:0]        raw,
  input  logic                       present,
  input  logic signed [OFFSET_W-1:0] offset,
  input  logic [SCALE_W-1:0]         scale,
  output cal_t                       cal
);

  localparam int SUM_W = ((RAW_BITS + 1 > OFFSET_W) ? RAW_BITS + 1 : OFFSET_W) + 1;
  localparam int PROD_W = SUM_W + SCALE_W + 1;
  localparam int FL_W = PROD_W - SCALE_SH;

  logic signed [SUM_W-1:0]  sum;
  logic signed [PROD_W-1:0] prod;
  logic                     present_q;
  logic signed [FL_W-1:0]   fl;
  cal_t                     cal_next;

  assign sum = SUM_W'($signed({1'b0, raw})) + SUM_W'(offset);
  assign fl  = FL_W'(prod >>> SCALE_SH);

  always_comb begin
    if (fl < CAL_MIN) begin
      cal_next = CAL_MIN;
    end else if (fl > CAL_MAX) begin
      cal_next = CAL_MAX;
    end else begin
      cal_next = cal_t'(fl);
    end
    if (SNAP && cal_next > SNAP_LO && cal_next < SNAP_HI) begin
      cal_next = CAL_CENTER;
    end
    if (!present_q) begin
      cal_next = CAL_ABSENT;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      prod      <= PROD_W'(sum) * PROD_W'($signed({1'b0, scale}));
      present_q <= present;
    end
    if (ctl.cal_en) begin
      cal <= cal_next;
    end
  end

endmodule

// File: hw/rtl/rcatt_merge.sv
// Merge stage: arm logic, roll and pitch setpoints, yaw integration and wrap.
// Depends on rcatt_pkg; takes the four calibrated lane values.
module rcatt_merge import rcatt_pkg::*; #(
  parameter int MAX_TILT_Q8 = 7680,
  parameter int YAW_STEP_Q8 = 256
) (
  input  logic                    clk,
  input  logic                    rst,
  input  stage_ctl_t              ctl,
  input  cal_t                    cal [NUM_CH],
  input  logic                    link,
  input  logic signed [IMU_W-1:0] imu_yaw,
  output res_t                    res
);

  localparam int SP_ROLL = 0;
  localparam int SP_PITCH = 1;
  localparam int SP_YAW = 2;
  localparam int NUM_SP = 3;
  localparam int MAXK = (MAX_TILT_Q8 > YAW_STEP_Q8) ? MAX_TILT_Q8 : YAW_STEP_Q8;
  localparam int D_W = CAL_W + 1;
  localparam int N_W = $clog2(1500 * MAXK + DIV_BIAS + 1) + 1;
  localparam int X_W = N_W - 1;
  localparam int P_W = X_W + RECIP_W;
  localparam int Q_W = N_W - 9;
  localparam int S_W = Q_W + 1;
  localparam int T_W = ((S_W > YAW_W) ? S_W : YAW_W) + 2;

  logic                    armed;
  logic signed [YAW_W-1:0] yaw_target;
  logic                    arm_set;
  logic                    arm_clr;
  logic                    link_q;
  logic signed [N_W-1:0]   n   [NUM_SP];
  logic                    neg [NUM_SP];
  logic [X_W-1:0]          x   [NUM_SP];
  logic [Q_W-1:0]          q   [NUM_SP];

  logic signed [D_W-1:0]   d_roll;
  logic signed [D_W-1:0]   d_pitch;
  logic signed [D_W-1:0]   d_rud;
  logic signed [S_W-1:0]   sq  [NUM_SP];
  logic signed [S_W-1:0]   step;
  logic signed [YAW_W-1:0] imu_sat;
  logic signed [YAW_W-1:0] base;
  logic signed [T_W-1:0]   t;
  logic signed [T_W-1:0]   t_wrap;
  logic signed [SP_W-1:0]  sp  [2];
  logic                    armed_next;

  assign d_roll  = D_W'(cal[CH_ROLL]) - D_W'(CAL_CENTER);
  assign d_pitch = D_W'(cal[CH_PITCH]) - D_W'(CAL_CENTER);
  assign d_rud   = D_W'(cal[CH_RUD]) - D_W'(CAL_CENTER);

  always_ff @(posedge clk) begin
    if (ctl.mul_en) begin
      link_q  <= link;
      arm_set <= cal[CH_THR] < ARM_THR_LIM && cal[CH_RUD] > ARM_RUD_LIM;
      arm_clr <= (cal[CH_THR] < DISARM_LIM && cal[CH_RUD] < DISARM_LIM) || !link;
      n[SP_ROLL]  <= link ? N_W'(d_roll) * N_W'(MAX_TILT_Q8) : '0;
      n[SP_PITCH] <= link ? N_W'(d_pitch) * N_W'(MAX_TILT_Q8) : '0;
      n[SP_YAW]   <= (link && cal[CH_THR] > ARM_THR_LIM) ?
                     N_W'(d_rud) * N_W'(YAW_STEP_Q8) : '0;
    end
    for (int i = 0; i < NUM_SP; i++) begin
      if (ctl.abs_en) begin
        neg[i] <= n[i] < 0;
        x[i]   <= X_W'((n[i] < 0) ? -n[i] : n[i]) + X_W'(DIV_BIAS);
      end
      if (ctl.div_en) begin
        q[i] <= Q_W'((P_W'(x[i]) * P_W'(DIV_RECIP)) >> DIV_SH);
      end
    end
  end

  always_comb begin
    for (int i = 0; i < NUM_SP; i++) begin
      sq[i] = neg[i] ? -$signed({1'b0, q[i]}) : $signed({1'b0, q[i]});
    end
    for (int i = 0; i < 2; i++) begin
      if (sq[i] > TILT_LIM) begin
        sp[i] = TILT_LIM;
      end else if (sq[i] < -TILT_LIM) begin
        sp[i] = -TILT_LIM;
      end else begin
        sp[i] = SP_W'(sq[i]);
      end
    end
    step = -sq[SP_YAW];

    if (imu_yaw > HALF_TURN) begin
      imu_sat = YAW_W'(HALF_TURN);
    end else if (imu_yaw < -HALF_TURN) begin
      imu_sat = YAW_W'(-HALF_TURN);
    end else begin
      imu_sat = imu_yaw;
    end
    base = arm_set ? imu_sat : yaw_target;
    t = T_W'(base) + T_W'(step);
    if (t < -T_W'(HALF_TURN)) begin
      t_wrap = t + T_W'(FULL_TURN);
    end else if (t > T_W'(HALF_TURN)) begin
      t_wrap = t - T_W'(FULL_TURN);
    end else begin
      t_wrap = t;
    end

    armed_next = arm_clr ? 1'b0 : (arm_set ? 1'b1 : armed);

    res.armed = armed_next;
    res.link  = link_q;
    res.roll  = sp[SP_ROLL];
    res.pitch = sp[SP_PITCH];
    res.yaw   = YAW_W'(t_wrap);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      armed      <= 1'b1;
      yaw_target <= '0;
    end else if (ctl.commit) begin
      armed      <= armed_next;
      yaw_target <= res.yaw;
    end
  end

endmodule

// File: hw/rtl/rc_stick_to_attitude_setpoint.sv
// RC stick to attitude setpoint, top level.
// Depends on rcatt_pkg, rcatt_if, rcatt_lane and rcatt_merge.
//
// Usage:
//   sticks carries one word per control tick: four raw stick readings, their
//   presence bits and the measured yaw. setpoints returns one word per tick:
//   armed flag, link flag, roll and pitch setpoints and the yaw target.
//   The user writes registers (cfg_we, cfg_index, cfg_data) only while idle.
// Timing:
//   Four calibration lanes (one multiplier each) run side by side, then the
//   merge stage steps through product, magnitude, reciprocal divide and
//   commit. The lanes multiply as a word is accepted; the five-step sequencer
//   (calibrate, product, magnitude, divide, commit) runs; sticks.ready
//   stays low until commit: no new word is taken before the last one is done.
// Reset:
//   Synchronous rst restores gains of one, zero offsets, armed set and a yaw
//   target of zero, and empties the output register.
// Stall:
//   The result waits in the output register; a next word may be accepted
//   meanwhile, and its commit holds until setpoints.ready frees the register.
module rc_stick_to_attitude_setpoint import rcatt_pkg::*; #(
  parameter int MAX_TILT_Q8 = 7680,
  parameter int YAW_STEP_Q8 = 256,
  parameter int RAW_BITS = 12
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  rcatt_in_if.sink              sticks,
  rcatt_out_if.source           setpoints
);

  localparam logic [2:0] ST_CAL = 3'd0;
  localparam logic [2:0] ST_MUL = 3'd1;
  localparam logic [2:0] ST_ABS = 3'd2;
  localparam logic [2:0] ST_DIV = 3'd3;
  localparam logic [2:0] ST_COMMIT = 3'd4;

  logic                       busy;
  logic [2:0]                 state;
  logic                       link;
  logic signed [IMU_W-1:0]    imu_q;
  logic signed [OFFSET_W-1:0] offset [NUM_CH];
  logic [SCALE_W-1:0]         scale  [NUM_CH];
  cal_t                       cal    [NUM_CH];
  stage_ctl_t                 ctl;
  res_t                       res;
  logic                       out_free;

  assign sticks.ready = !busy && !rst;
  assign out_free     = !setpoints.valid || setpoints.ready;

  always_comb begin
    ctl.load   = sticks.valid && sticks.ready;
    ctl.cal_en = busy && state == ST_CAL;
    ctl.mul_en = busy && state == ST_MUL;
    ctl.abs_en = busy && state == ST_ABS;
    ctl.div_en = busy && state == ST_DIV;
    ctl.commit = busy && state == ST_COMMIT && out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_CH; i++) begin
        offset[i] <= '0;
        scale[i]  <= SCALE_ONE;
      end
    end else if (cfg_we) begin
      case (cfg_index)
        REG_OFFSET_ROLL:    offset[CH_ROLL]  <= cfg_data[OFFSET_W-1:0];
        REG_OFFSET_PITCH:   offset[CH_PITCH] <= cfg_data[OFFSET_W-1:0];
        REG_OFFSET_RUD:     offset[CH_RUD]   <= cfg_data[OFFSET_W-1:0];
        REG_OFFSET_THR:     offset[CH_THR]   <= cfg_data[OFFSET_W-1:0];
        REG_SCALE_ROLL:     scale[CH_ROLL]   <= cfg_data[SCALE_W-1:0];
        REG_SCALE_PITCH:    scale[CH_PITCH]  <= cfg_data[SCALE_W-1:0];
        REG_SCALE_RUD:      scale[CH_RUD]    <= cfg_data[SCALE_W-1:0];
        REG_SCALE_THR:      scale[CH_THR]    <= cfg_data[SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      state <= ST_CAL;
    end else if (ctl.load) begin
      busy  <= 1'b1;
      state <= ST_CAL;
    end else if (busy) begin
      if (state == ST_COMMIT) begin
        if (out_free) begin
          busy <= 1'b0;
        end
      end else begin
        state <= state + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      link  <= &sticks.present_mask;
      imu_q <= sticks.imu_yaw;
    end
  end

  rcatt_lane #(.RAW_BITS(RAW_BITS), .SNAP(1'b1)) u_lane_roll (
    .clk(clk), .ctl(ctl), .raw(sticks.raw_roll), .present(sticks.present_mask[CH_ROLL]),
    .offset(offset[CH_ROLL]), .scale(scale[CH_ROLL]), .cal(cal[CH_ROLL])
  );
  rcatt_lane #(.RAW_BITS(RAW_BITS), .SNAP(1'b1)) u_lane_pitch (
    .clk(clk), .ctl(ctl), .raw(sticks.raw_pitch), .present(sticks.present_mask[CH_PITCH]),
    .offset(offset[CH_PITCH]), .scale(scale[CH_PITCH]), .cal(cal[CH_PITCH])
  );
  rcatt_lane #(.RAW_BITS(RAW_BITS), .SNAP(1'b1)) u_lane_rud (
    .clk(clk), .ctl(ctl), .raw(sticks.raw_yaw_stick), .present(sticks.present_mask[CH_RUD]),
    .offset(offset[CH_RUD]), .scale(scale[CH_RUD]), .cal(cal[CH_RUD])
  );
  rcatt_lane #(.RAW_BITS(RAW_BITS), .SNAP(1'b0)) u_lane_thr (
    .clk(clk), .ctl(ctl), .raw(sticks.raw_throttle), .present(sticks.present_mask[CH_THR]),
    .offset(offset[CH_THR]), .scale(scale[CH_THR]), .cal(cal[CH_THR])
  );

  rcatt_merge #(.MAX_TILT_Q8(MAX_TILT_Q8), .YAW_STEP_Q8(YAW_STEP_Q8)) u_merge (
    .clk(clk), .rst(rst), .ctl(ctl), .cal(cal), .link(link), .imu_yaw(imu_q), .res(res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      setpoints.valid <= 1'b0;
    end else if (ctl.commit) begin
      setpoints.valid <= 1'b1;
    end else if (setpoints.ready) begin
      setpoints.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.commit) begin
      setpoints.armed_flag     <= res.armed;
      setpoints.link_ok        <= res.link;
      setpoints.roll_setpoint  <= res.roll;
      setpoints.pitch_setpoint <= res.pitch;
      setpoints.yaw_setpoint   <= res.yaw;
    end
  end

endmodule

// File: hw/rtl/rcatt_checker.sv
// Port-level checker for the RC setpoint block, bound to the top level.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module rcatt_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic               armed_flag,
  input logic               link_ok,
  input logic signed [15:0] roll_setpoint,
  input logic signed [15:0] pitch_setpoint,
  input logic signed [16:0] yaw_setpoint
);

  `RCATT_ASSERT_ALWAYS(a_reset_empty, clk, rst |=> !out_valid)
  `RCATT_ASSERT(a_busy_after_take, clk, rst, (in_valid && in_ready) |=> !in_ready)
  `RCATT_ASSERT(a_stall_holds, clk, rst, (out_valid && !out_ready) |=> (out_valid && $stable(yaw_setpoint) && $stable(roll_setpoint)))
  `RCATT_ASSERT(a_link_lost, clk, rst, (out_valid && !link_ok) |-> (!armed_flag && roll_setpoint == 16'sd0 && pitch_setpoint == 16'sd0))
  `RCATT_ASSERT(a_yaw_range, clk, rst, out_valid |-> (yaw_setpoint <= 17'sd46080 && yaw_setpoint >= -17'sd46080))

endmodule

bind rc_stick_to_attitude_setpoint rcatt_checker u_rcatt_checker (
  .clk(clk),
  .rst(rst),
  .in_valid(sticks.valid),
  .in_ready(sticks.ready),
  .out_valid(setpoints.valid),
  .out_ready(setpoints.ready),
  .armed_flag(setpoints.armed_flag),
  .link_ok(setpoints.link_ok),
  .roll_setpoint(setpoints.roll_setpoint),
  .pitch_setpoint(setpoints.pitch_setpoint),
  .yaw_setpoint(setpoints.yaw_setpoint)
);
